// ===== design/assert_macros.svh =====
// Assertion macros shared by the sparse product RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in the same cycle implies consequent
`define CSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define CSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/csr_spmv_pkg.sv =====
// Types and constants of the compressed-row sparse matrix-vector product.
// No dependencies.
`default_nettype none

package csr_spmv_pkg;

    localparam int MAX_N   = 256;
    localparam int MAX_NNZ = 4096;

    localparam int RS_AW   = $clog2(MAX_N + 1);   // row-start table address
    localparam int NZ_AW   = $clog2(MAX_NNZ);     // nonzero slot address
    localparam int VEC_AW  = $clog2(MAX_N);       // vector address
    localparam int SLOT_W  = NZ_AW + 1;           // slot pointer, holds MAX_NNZ itself
    localparam int SIZE_W  = 9;                   // matrix_size register
    localparam int VAL_W   = 32;                  // Q8.24 word
    localparam int PROD_W  = 2 * VAL_W;           // Q16.48 product
    localparam int TERM_W  = PROD_W - 24;         // product floored to Q16.24
    localparam int ACC_W   = TERM_W + NZ_AW;      // cannot overflow over a full row

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    typedef enum logic [1:0] {
        MODE_ROW_START = 2'd0,
        MODE_NONZERO   = 2'd1,
        MODE_VECTOR    = 2'd2,
        MODE_COMPUTE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PTR,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== design/csr_sparse_matrix_vector_product.sv =====
// Top level of the compressed-row sparse matrix times dense vector block.
// Depends on csr_spmv_pkg and assert_macros.svh.
//
//  channel  | direction | handshake                  | contents
//  ---------+-----------+----------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | load or compute word
//  m_axis   | out       | m_axis_tvalid/tready       | one row result per compute
//  cfg      | in        | cfg_we, no wait            | matrix_size
//
// Loads are taken back to back while the block is idle. A compute word on a
// row with nonzeros reads the row pointers, then the nonzeros in turn on the
// slot memory read port; the vector read, multiplier and accumulator drain,
// the block sees them empty and loads the result register. A bad row skips
// the walk and an empty row leaves it at once. The next word is taken in the
// cycle after the result is loaded. Reset is synchronous and clears control
// only; the memories hold garbage until loaded. The result register lets new
// loads in while it waits; a finished row holds until m_axis_tready frees the
// result register.
`default_nettype none

module csr_sparse_matrix_vector_product (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [csr_spmv_pkg::SIZE_W-1:0]     cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // index[11:0], column[19:12], number[51:20], start_slot[64:52], zero[71:65]
    input  wire logic [csr_spmv_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  wire logic [csr_spmv_pkg::S_USER_W-1:0]   s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // row_number[7:0], row_sum[39:8]
    output logic [csr_spmv_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // saturated[0], error[1]
    output logic [csr_spmv_pkg::M_USER_W-1:0]        m_axis_tuser
);

    `include "assert_macros.svh"

    localparam int RS_AW  = csr_spmv_pkg::RS_AW;
    localparam int NZ_AW  = csr_spmv_pkg::NZ_AW;
    localparam int VEC_AW = csr_spmv_pkg::VEC_AW;
    localparam int SLOT_W = csr_spmv_pkg::SLOT_W;
    localparam int SIZE_W = csr_spmv_pkg::SIZE_W;
    localparam int VAL_W  = csr_spmv_pkg::VAL_W;
    localparam int PROD_W = csr_spmv_pkg::PROD_W;
    localparam int TERM_W = csr_spmv_pkg::TERM_W;
    localparam int ACC_W  = csr_spmv_pkg::ACC_W;
    localparam int IDX_W  = 12;
    localparam int COL_W  = 8;

    // ---------------- input word unpacking
    logic [IDX_W-1:0]         in_index;
    logic [COL_W-1:0]         in_column;
    logic [VAL_W-1:0]         in_number;
    logic [SLOT_W-1:0]        in_start;
    csr_spmv_pkg::mode_t      in_mode;

    assign in_index  = s_axis_tdata[11:0];
    assign in_column = s_axis_tdata[19:12];
    assign in_number = s_axis_tdata[51:20];
    assign in_start  = s_axis_tdata[64:52];
    assign in_mode   = csr_spmv_pkg::mode_t'(s_axis_tuser);

    logic s_accept;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration
    logic [SIZE_W-1:0] matrix_size_reg;
    logic [SIZE_W-1:0] size_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= '0;
        end else if (cfg_we) begin
            matrix_size_reg <= cfg_wdata;
        end
    end

    assign size_eff = (matrix_size_reg < SIZE_W'(csr_spmv_pkg::MAX_N)) ?
                      matrix_size_reg : SIZE_W'(csr_spmv_pkg::MAX_N);

    // ---------------- memories
    logic [SLOT_W-1:0]        rs_mem  [csr_spmv_pkg::MAX_N+1];
    logic [COL_W+VAL_W-1:0]   nz_mem  [csr_spmv_pkg::MAX_NNZ];
    logic [VAL_W-1:0]         vec_mem [csr_spmv_pkg::MAX_N];

    logic                     rs_we, nz_we, vec_we;
    logic [RS_AW-1:0]         rs_addr_lo, rs_addr_hi;
    logic [SLOT_W-1:0]        rs_lo_q, rs_hi_q;
    logic [NZ_AW-1:0]         nz_raddr;
    logic [COL_W+VAL_W-1:0]   nz_q;
    logic [VEC_AW-1:0]        vec_raddr;
    logic [VAL_W-1:0]         vec_q;

    always_comb begin
        rs_we  = 1'b0;
        nz_we  = 1'b0;
        vec_we = 1'b0;
        if (s_accept) begin
            case (in_mode)
                csr_spmv_pkg::MODE_ROW_START:
                    rs_we = in_index <= IDX_W'(csr_spmv_pkg::MAX_N);
                csr_spmv_pkg::MODE_NONZERO:
                    nz_we = {1'b0, in_index} < (IDX_W+1)'(csr_spmv_pkg::MAX_NNZ);
                csr_spmv_pkg::MODE_VECTOR:
                    vec_we = in_index < IDX_W'(csr_spmv_pkg::MAX_N);
                default: ;
            endcase
        end
    end

    assign rs_addr_lo = in_index[RS_AW-1:0];
    assign rs_addr_hi = in_index[RS_AW-1:0] + RS_AW'(1);

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            rs_mem[rs_addr_lo] <= in_start;
        end
        rs_lo_q <= rs_mem[rs_addr_lo];
        rs_hi_q <= rs_mem[rs_addr_hi];
    end

    always_ff @(posedge aclk) begin
        if (nz_we) begin
            nz_mem[in_index[NZ_AW-1:0]] <= {in_number, in_column};
        end
        nz_q <= nz_mem[nz_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[in_index[VEC_AW-1:0]] <= in_number;
        end
        vec_q <= vec_mem[vec_raddr];
    end

    // ---------------- control
    csr_spmv_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]  k_reg, k_next;
    logic [SLOT_W-1:0]  hi_reg, hi_next;
    logic [COL_W-1:0]   row_reg;
    logic               bad_row_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic               issue;
    logic               ptr_bad;
    logic               acc_clear;
    logic               out_load;
    logic               out_err;

    assign ptr_bad = bad_row_reg || (rs_lo_q > rs_hi_q) ||
                     (rs_hi_q > SLOT_W'(csr_spmv_pkg::MAX_NNZ));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csr_spmv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        k_next        = k_reg;
        hi_next       = hi_reg;
        issue         = 1'b0;
        acc_clear     = 1'b0;
        out_load      = 1'b0;
        out_err       = 1'b0;
        unique case (state_reg)
            csr_spmv_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_accept && in_mode == csr_spmv_pkg::MODE_COMPUTE) begin
                    state_next = csr_spmv_pkg::ST_PTR;
                end
            end
            csr_spmv_pkg::ST_PTR: begin
                acc_clear = 1'b1;
                k_next    = rs_lo_q;
                hi_next   = rs_hi_q;
                state_next = ptr_bad ? csr_spmv_pkg::ST_FINISH : csr_spmv_pkg::ST_WALK;
            end
            csr_spmv_pkg::ST_WALK: begin
                if (k_reg < hi_reg) begin
                    issue  = 1'b1;
                    k_next = k_reg + SLOT_W'(1);
                end else if (!v1_reg && !v2_reg && !v3_reg) begin
                    state_next = csr_spmv_pkg::ST_FINISH;
                end
            end
            csr_spmv_pkg::ST_FINISH: begin
                // hold until the result register is free
                out_err = bad_row_reg || (k_reg > hi_reg);
                if (!m_axis_tvalid || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = csr_spmv_pkg::ST_IDLE;
                end
            end
            default: state_next = csr_spmv_pkg::ST_IDLE;
        endcase
    end

    // A bad pointer pair is remembered as k above hi, which a walk never leaves.
    always_ff @(posedge aclk) begin
        if (state_reg == csr_spmv_pkg::ST_PTR && ptr_bad) begin
            k_reg  <= SLOT_W'(1);
            hi_reg <= '0;
        end else begin
            k_reg  <= k_next;
            hi_reg <= hi_next;
        end
        if (s_accept) begin
            row_reg     <= in_index[COL_W-1:0];
            bad_row_reg <= {1'b0, in_index} >= (IDX_W+1)'(size_eff);
        end
    end

    // ---------------- walk pipeline
    logic [VAL_W-1:0]          val2_reg;
    logic                      use2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    assign nz_raddr  = k_reg[NZ_AW-1:0];
    assign vec_raddr = nz_q[COL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && use2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val2_reg <= nz_q[COL_W+VAL_W-1:COL_W];
        use2_reg <= {1'b0, nz_q[COL_W-1:0]} < size_eff;
        prod_reg <= $signed(val2_reg) * $signed(vec_q);
        if (acc_clear) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            // floor to Q16.24 by dropping the low 24 bits
            acc_reg <= acc_reg + ACC_W'($signed(prod_reg[PROD_W-1:PROD_W-TERM_W]));
        end
    end

    // ---------------- saturation and result register
    logic                in_range;
    logic [VAL_W-1:0]    sum_sat;

    assign in_range = (&acc_reg[ACC_W-1:VAL_W-1]) || !(|acc_reg[ACC_W-1:VAL_W-1]);
    assign sum_sat  = in_range ? acc_reg[VAL_W-1:0] :
                      (acc_reg[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                        : {1'b0, {(VAL_W-1){1'b1}}});

    logic                m_valid_reg;
    logic [COL_W-1:0]    m_row_reg;
    logic [VAL_W-1:0]    m_sum_reg;
    logic                m_sat_reg;
    logic                m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_row_reg <= row_reg;
            m_sum_reg <= out_err ? '0 : sum_sat;
            m_sat_reg <= !out_err && !in_range;
            m_err_reg <= out_err;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_sum_reg, m_row_reg};
    assign m_axis_tuser  = {m_err_reg, m_sat_reg};

    // ---------------- checks
    `CSR_ASSERT_IMPL(a_idle_drained, s_axis_tready, !v1_reg && !v2_reg && !v3_reg,
                     "input taken while products are in flight")
    `CSR_ASSERT_IMPL(a_finish_drained, state_reg == csr_spmv_pkg::ST_FINISH,
                     !v1_reg && !v2_reg && !v3_reg, "row sum taken before pipeline drained")
    `CSR_ASSERT_IMPL(a_walk_bounded, state_reg == csr_spmv_pkg::ST_WALK, k_reg <= hi_reg,
                     "slot pointer ran past row end")
    `CSR_ASSERT_NEXT(a_compute_ptr, s_accept && in_mode == csr_spmv_pkg::MODE_COMPUTE,
                     state_reg == csr_spmv_pkg::ST_PTR, "compute word did not fetch pointers")

endmodule

`default_nettype wire

// ===== dv/csr_spmv_checker.sv =====
// Result checker for the compressed-row sparse matrix-vector product.
// Watches cfg, s_axis and m_axis, keeps its own copy of the tables and predicts
// every row result. Depends on csr_spmv_pkg.
`default_nettype none

module csr_spmv_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [csr_spmv_pkg::SIZE_W-1:0]     cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    // index[11:0], column[19:12], number[51:20], start_slot[64:52], zero[71:65]
    input  wire logic [csr_spmv_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  wire logic [csr_spmv_pkg::S_USER_W-1:0]   s_axis_tuser,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // row_number[7:0], row_sum[39:8]
    input  wire logic [csr_spmv_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // saturated[0], error[1]
    input  wire logic [csr_spmv_pkg::M_USER_W-1:0]   m_axis_tuser,
    output int                                       mismatches,
    output int                                       rows_pending
);

    localparam int     MAX_N        = csr_spmv_pkg::MAX_N;
    localparam int     MAX_NNZ      = csr_spmv_pkg::MAX_NNZ;
    localparam int     SLOT_W       = csr_spmv_pkg::SLOT_W;
    localparam int     SIZE_W       = csr_spmv_pkg::SIZE_W;
    localparam int     REPORT_LIMIT = 10;
    localparam longint SUM_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SUM_MIN      = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [7:0]  row_number;
        logic [31:0] row_sum;
        logic        saturated;
        logic        error;
    } row_result_t;

    logic [SLOT_W-1:0] row_start  [0:MAX_N];
    logic [7:0]        nz_column  [0:MAX_NNZ-1];
    logic [31:0]       nz_value   [0:MAX_NNZ-1];
    logic [31:0]       vec_value  [0:MAX_N-1];
    logic [SIZE_W-1:0] size_reg;
    row_result_t       expected_rows [$];

    initial begin
        mismatches   = 0;
        rows_pending = 0;
        size_reg     = '0;
    end

    // Dot product of one row with the vector, floored per term, clamped to 32 bits
    function automatic row_result_t predict_row(input logic [11:0] row);
        row_result_t res;
        int unsigned n, lo, hi, k;
        longint      acc, a, b;
        res.row_number = row[7:0];
        res.row_sum    = '0;
        res.saturated  = 1'b0;
        res.error      = 1'b0;
        n = (size_reg < MAX_N) ? size_reg : MAX_N;
        if (row >= n) begin
            res.error = 1'b1;
            return res;
        end
        lo = row_start[row];
        hi = row_start[row + 1];
        if (lo > hi || hi > MAX_NNZ) begin
            res.error = 1'b1;
            return res;
        end
        acc = 0;
        for (k = lo; k < hi; k++) begin
            if (nz_column[k] < n) begin
                a = longint'($signed(nz_value[k]));
                b = longint'($signed(vec_value[nz_column[k]]));
                acc += (a * b) >>> 24;
            end
        end
        if (acc > SUM_MAX) begin
            acc           = SUM_MAX;
            res.saturated = 1'b1;
        end else if (acc < SUM_MIN) begin
            acc           = SUM_MIN;
            res.saturated = 1'b1;
        end
        res.row_sum = acc[31:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        row_result_t got, want;
        logic [11:0] idx;
        if (!aresetn) begin
            size_reg = '0;
        end else begin
            if (cfg_we) begin
                size_reg = cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.row_number = m_axis_tdata[7:0];
                got.row_sum    = m_axis_tdata[39:8];
                got.saturated  = m_axis_tuser[0];
                got.error      = m_axis_tuser[1];
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result word: row %0d sum %h sat %b err %b",
                                 got.row_number, got.row_sum, got.saturated, got.error);
                end else begin
                    want = expected_rows.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result mismatch: expected row %0d sum %h sat %b err %b",
                                     want.row_number, want.row_sum, want.saturated,
                                     want.error);
                            $display("                 got      row %0d sum %h sat %b err %b",
                                     got.row_number, got.row_sum, got.saturated, got.error);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                idx = s_axis_tdata[11:0];
                case (csr_spmv_pkg::mode_t'(s_axis_tuser))
                    csr_spmv_pkg::MODE_ROW_START: begin
                        if (idx <= MAX_N)
                            row_start[idx] = s_axis_tdata[64:52];
                    end
                    csr_spmv_pkg::MODE_NONZERO: begin
                        nz_column[idx] = s_axis_tdata[19:12];
                        nz_value[idx]  = s_axis_tdata[51:20];
                    end
                    csr_spmv_pkg::MODE_VECTOR: begin
                        if (idx < MAX_N)
                            vec_value[idx] = s_axis_tdata[51:20];
                    end
                    default: begin
                        expected_rows = {expected_rows, predict_row(idx)};
                    end
                endcase
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_csr_sparse_matrix_vector_product.sv =====
// Testbench top for the compressed-row sparse matrix-vector product.
// Drives load and compute words plus matrix_size writes, gives the verdict.
// Depends on csr_spmv_pkg, csr_spmv_checker and the block itself.
`default_nettype none

module tb_csr_sparse_matrix_vector_product;

    localparam int MAX_N         = csr_spmv_pkg::MAX_N;
    localparam int MAX_NNZ       = csr_spmv_pkg::MAX_NNZ;
    localparam int SIZE_W        = csr_spmv_pkg::SIZE_W;
    localparam int S_DATA_W      = csr_spmv_pkg::S_DATA_W;
    localparam int S_USER_W      = csr_spmv_pkg::S_USER_W;
    localparam int M_DATA_W      = csr_spmv_pkg::M_DATA_W;
    localparam int M_USER_W      = csr_spmv_pkg::M_USER_W;
    localparam int IDLE_PCT      = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 80;
    localparam int PHASE_ROWS    = 12;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [SIZE_W-1:0]     cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;   // index, column, number, start_slot, zero
    logic [S_USER_W-1:0]   s_axis_tuser  = '0;   // mode
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire logic [M_DATA_W-1:0] m_axis_tdata;      // row_number, row_sum
    wire logic [M_USER_W-1:0] m_axis_tuser;      // saturated, error

    int mismatch_count;
    int rows_pending;
    int cycle_count = 0;

    // Which table entries hold data, so that no compute reads an unwritten one
    logic [12:0]  rs_val [0:MAX_N];
    bit           rs_ok  [0:MAX_N];
    logic [7:0]   nz_col [0:MAX_NNZ-1];
    bit           nz_ok  [0:MAX_NNZ-1];
    bit           vec_ok [0:MAX_N-1];

    int unsigned  size_now   = 0;
    int           words_sent = 0;
    int           rows_sent  = 0;
    bit           steady     = 1'b0;

    csr_sparse_matrix_vector_product u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    csr_spmv_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatch_count),
        .rows_pending  (rows_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_csr_sparse_matrix_vector_product: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Full-range words and words within plus or minus one in equal parts, some extremes
    function automatic logic [31:0] random_q824();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6, 7: w = {{7{w[24]}}, w[24:0]};
            default: begin
                case ($urandom_range(0, 4))
                    0:       w = 32'h8000_0000;
                    1:       w = 32'h7FFF_FFFF;
                    2:       w = 32'h0000_0000;
                    3:       w = 32'hFFFF_FFFF;
                    default: w = 32'h0100_0000;
                endcase
            end
        endcase
        return w;
    endfunction

    // True when computing row r reads only entries already written
    function automatic bit row_is_defined(input int unsigned r);
        int unsigned lo, hi, k;
        if (r >= size_now)
            return 1'b1;
        if (!rs_ok[r] || !rs_ok[r + 1])
            return 1'b0;
        lo = rs_val[r];
        hi = rs_val[r + 1];
        if (lo > hi || hi > MAX_NNZ)
            return 1'b1;
        for (k = lo; k < hi; k++)
            if (!nz_ok[k] || !vec_ok[nz_col[k]])
                return 1'b0;
        return 1'b1;
    endfunction

    // Present one word, hold it until accepted, then note what it wrote
    task automatic push_word(input csr_spmv_pkg::mode_t mode, input logic [31:0] index,
                             input logic [31:0] column, input logic [31:0] number,
                             input logic [31:0] start_slot);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, start_slot[12:0], number[31:0], column[7:0], index[11:0]};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        case (mode)
            csr_spmv_pkg::MODE_ROW_START: begin
                if (index[11:0] <= MAX_N) begin
                    rs_val[index[11:0]] = start_slot[12:0];
                    rs_ok[index[11:0]]  = 1'b1;
                    words_sent++;
                end
            end
            csr_spmv_pkg::MODE_NONZERO: begin
                nz_col[index[11:0]] = column[7:0];
                nz_ok[index[11:0]]  = 1'b1;
                words_sent++;
            end
            csr_spmv_pkg::MODE_VECTOR: begin
                if (index[11:0] < MAX_N) begin
                    vec_ok[index[11:0]] = 1'b1;
                    words_sent++;
                end
            end
            default: begin
                words_sent++;
                rows_sent++;
            end
        endcase
    endtask

    // Drain all rows, let the block settle, then write matrix_size
    task automatic configure_size(input int unsigned size);
        s_axis_tvalid <= 1'b0;
        while (rows_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size[SIZE_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        size_now  = size;
    endtask

    // Lay out a fresh row with random nonzeros, fill missing vector words, compute it
    task automatic load_row_and_compute();
        int unsigned r, len, lo, k, col;
        r   = $urandom_range(0, size_now - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        lo  = ($urandom_range(0, 7) == 0) ? MAX_NNZ - len : $urandom_range(0, MAX_NNZ - len);
        push_word(csr_spmv_pkg::MODE_ROW_START, r, $urandom, $urandom, lo);
        push_word(csr_spmv_pkg::MODE_ROW_START, r + 1, $urandom, $urandom, lo + len);
        for (k = lo; k < lo + len; k++) begin
            col = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, size_now - 1);
            push_word(csr_spmv_pkg::MODE_NONZERO, k, col, random_q824(),
                      $urandom_range(0, MAX_NNZ));
        end
        for (k = lo; k < lo + len; k++) begin
            if (!vec_ok[nz_col[k]] || $urandom_range(0, 9) == 0)
                push_word(csr_spmv_pkg::MODE_VECTOR, nz_col[k], $urandom, random_q824(),
                          $urandom_range(0, MAX_NNZ));
        end
        push_word(csr_spmv_pkg::MODE_COMPUTE, r, $urandom, $urandom,
                  $urandom_range(0, MAX_NNZ));
    endtask

    initial begin : stimulus
        int          phase, pick, t, words_start, rows_start;
        int unsigned r, lo, hi;
        bit          found;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: size 0 makes every row an error
        push_word(csr_spmv_pkg::MODE_COMPUTE, 0, 8'h00, 32'h0, 0);
        configure_size(4);
        // row 0: one slot, max times max; row 1: min times max plus a column past
        // the size; row 2: start above end; row 3: empty
        push_word(csr_spmv_pkg::MODE_ROW_START, 0, 8'hFF, 32'hFFFF_FFFF, 0);
        push_word(csr_spmv_pkg::MODE_ROW_START, 1, 8'h00, 32'h0, 1);
        push_word(csr_spmv_pkg::MODE_ROW_START, 2, 8'h00, 32'h0, 3);
        push_word(csr_spmv_pkg::MODE_ROW_START, 3, 8'h00, 32'h0, 1);
        push_word(csr_spmv_pkg::MODE_ROW_START, 4, 8'h00, 32'h0, 1);
        push_word(csr_spmv_pkg::MODE_ROW_START, MAX_N, 8'h00, 32'h0, MAX_NNZ);
        push_word(csr_spmv_pkg::MODE_ROW_START, MAX_N + 1, 8'h00, 32'h0, 7);  // dropped
        push_word(csr_spmv_pkg::MODE_ROW_START, 4095, 8'h00, 32'h0, 9);       // dropped
        push_word(csr_spmv_pkg::MODE_NONZERO, 0, 0, 32'h7FFF_FFFF, 0);
        push_word(csr_spmv_pkg::MODE_NONZERO, 1, 1, 32'h8000_0000, 0);
        push_word(csr_spmv_pkg::MODE_NONZERO, 2, 255, 32'h7FFF_FFFF, 0);
        push_word(csr_spmv_pkg::MODE_NONZERO, MAX_NNZ - 1, 255, 32'h5A5A_5A5A, 0);
        push_word(csr_spmv_pkg::MODE_VECTOR, 0, 0, 32'h7FFF_FFFF, 0);
        push_word(csr_spmv_pkg::MODE_VECTOR, 1, 0, 32'h7FFF_FFFF, 0);
        push_word(csr_spmv_pkg::MODE_VECTOR, 255, 0, 32'h8000_0000, 0);
        push_word(csr_spmv_pkg::MODE_VECTOR, MAX_N, 0, 32'h1234_5678, 0);     // dropped
        push_word(csr_spmv_pkg::MODE_VECTOR, 4095, 0, 32'h1234_5678, 0);      // dropped
        push_word(csr_spmv_pkg::MODE_COMPUTE, 0, 0, 32'h0, 0);
        push_word(csr_spmv_pkg::MODE_COMPUTE, 1, 0, 32'h0, 0);
        push_word(csr_spmv_pkg::MODE_COMPUTE, 2, 0, 32'h0, 0);
        push_word(csr_spmv_pkg::MODE_COMPUTE, 3, 0, 32'h0, 0);
        push_word(csr_spmv_pkg::MODE_COMPUTE, 4, 0, 32'h0, 0);
        push_word(csr_spmv_pkg::MODE_COMPUTE, 4095, 0, 32'h0, 0);

        // Random phases, one matrix size each
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       configure_size(MAX_N);
                1:       configure_size(1);
                2:       configure_size($urandom_range(2, MAX_N - 1));
                3:       configure_size(0);
                default: configure_size(MAX_N - 1);
            endcase
            steady      = (phase == 2);
            words_start = words_sent;
            rows_start  = rows_sent;
            while (words_sent - words_start < PHASE_WORDS || rows_sent - rows_start < PHASE_ROWS)
            begin
                pick = $urandom_range(0, 99);
                // with no rows in use only error rows and stray loads apply
                if (size_now == 0)
                    pick = (pick < 50) ? 78 : 86;
                if (pick < 45) begin
                    load_row_and_compute();
                end else if (pick < 70) begin
                    found = 1'b0;
                    for (t = 0; t < 8 && !found; t++) begin
                        r     = $urandom_range(0, size_now - 1);
                        found = row_is_defined(r);
                    end
                    if (found)
                        push_word(csr_spmv_pkg::MODE_COMPUTE, r, $urandom, $urandom,
                                  $urandom_range(0, MAX_NNZ));
                    else
                        load_row_and_compute();
                end else if (pick < 78) begin
                    r  = $urandom_range(0, size_now - 1);
                    hi = $urandom_range(0, 4000);
                    lo = hi + $urandom_range(1, 96);
                    push_word(csr_spmv_pkg::MODE_ROW_START, r, $urandom, $urandom, lo);
                    push_word(csr_spmv_pkg::MODE_ROW_START, r + 1, $urandom, $urandom, hi);
                    push_word(csr_spmv_pkg::MODE_COMPUTE, r, $urandom, $urandom,
                              $urandom_range(0, MAX_NNZ));
                end else if (pick < 86) begin
                    push_word(csr_spmv_pkg::MODE_COMPUTE, $urandom_range(size_now, 4095),
                              $urandom, $urandom, $urandom_range(0, MAX_NNZ));
                end else begin
                    case ($urandom_range(0, 3))
                        0: push_word(csr_spmv_pkg::MODE_ROW_START,
                                     $urandom_range(MAX_N + 1, 4095), $urandom,
                                     $urandom, $urandom_range(0, MAX_NNZ));
                        1: push_word(csr_spmv_pkg::MODE_VECTOR,
                                     $urandom_range(MAX_N, 4095), $urandom,
                                     random_q824(), $urandom_range(0, MAX_NNZ));
                        2: push_word(csr_spmv_pkg::MODE_NONZERO,
                                     $urandom_range(0, MAX_NNZ - 1), $urandom,
                                     random_q824(), $urandom_range(0, MAX_NNZ));
                        default: push_word(csr_spmv_pkg::MODE_VECTOR,
                                           $urandom_range(0, MAX_N - 1), $urandom,
                                           random_q824(), $urandom_range(0, MAX_NNZ));
                    endcase
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (rows_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && rows_pending == 0)
            $display("tb_csr_sparse_matrix_vector_product: PASS");
        else
            $display("tb_csr_sparse_matrix_vector_product: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
